FILE: hdl/dtq_pkg.sv
package dtq_pkg;

    localparam int TIME_W = 48;
    localparam int ID_W   = 16;

    localparam logic [1:0] KIND_ABS   = 2'd0;
    localparam logic [1:0] KIND_DELAY = 2'd1;
    localparam logic [1:0] KIND_POLL  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic [1:0] OUT_FIRED    = 2'd0;
    localparam logic [1:0] OUT_RELEASED = 2'd1;
    localparam logic [1:0] OUT_REJECTED = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POLL   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [TIME_W-1:0] tm;
        logic [ID_W-1:0]   id;
    } t_cmd;

    typedef struct packed {
        logic [TIME_W-1:0] due;
        logic [ID_W-1:0]   id;
    } t_entry;

endpackage

FILE: hdl/dtq_front.sv
module dtq_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_kind,
    input  logic [dtq_pkg::TIME_W-1:0]  i_now_ms,
    input  logic [dtq_pkg::TIME_W-1:0]  i_when_ms,
    input  logic [dtq_pkg::ID_W-1:0]    i_unit_id,
    output dtq_pkg::t_cmd               o_cmd,
    output logic                        o_cmd_valid,
    input  logic                        i_pop
);
    import dtq_pkg::*;

    t_cmd              r_q [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;
    t_cmd              cmd_in;
    logic [TIME_W:0]   sum;
    logic              push, pop;

    always_comb begin
        sum = {1'b0, i_now_ms} + {1'b0, i_when_ms};
        cmd_in.id = i_unit_id;
        case (i_kind)
            KIND_ABS: begin
                cmd_in.op = OP_INSERT;
                cmd_in.tm = i_when_ms;
            end
            KIND_DELAY: begin
                cmd_in.op = OP_INSERT;
                cmd_in.tm = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
            end
            KIND_POLL: begin
                cmd_in.op = OP_POLL;
                cmd_in.tm = i_now_ms;
            end
            default: begin
                cmd_in.op = OP_CLEAR;
                cmd_in.tm = i_now_ms;
            end
        endcase
    end

    assign busy        = (r_cnt == 2'd2);
    assign push        = start && !busy;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = i_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: hdl/dtq_engine.sv
module dtq_engine #(
    parameter int CAPACITY = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dtq_pkg::t_cmd               i_cmd,
    input  logic                        i_cmd_valid,
    output logic                        o_pop,
    output logic                        o_res_valid,
    output logic [dtq_pkg::ID_W-1:0]    o_unit_id_res,
    output logic [1:0]                  o_outcome,
    output logic                        o_last
);
    import dtq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = $clog2(CAPACITY);
    localparam logic [CW:0]   CAP_S = (CW+1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE   = CW'(1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_INS_STEP = 7'b0000010,
        S_INS_CMP  = 7'b0000100,
        S_POLL_RD  = 7'b0001000,
        S_POLL_CMP = 7'b0010000,
        S_CLR_RD   = 7'b0100000,
        S_CLR_OUT  = 7'b1000000
    } t_state;

    function automatic logic [PW-1:0] idx(input logic [PW-1:0] head,
                                          input logic [CW-1:0] rel);
        logic [CW:0] s;
        s = (CW+1)'(head) + {1'b0, rel};
        if (s >= CAP_S) begin
            s = s - CAP_S;
        end
        return s[PW-1:0];
    endfunction

    t_entry            r_mem [CAPACITY];
    t_entry            r_rd;
    t_state            r_state, n_state;
    logic [PW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_p, n_p;
    t_entry            r_new, n_new;
    logic [TIME_W-1:0] r_now, n_now;
    logic [ID_W-1:0]   r_pend_id, n_pend_id;
    logic              r_have_pend, n_have_pend;
    logic              r_valid, n_valid;
    logic [ID_W-1:0]   r_id, n_id;
    logic [1:0]        r_outcome, n_outcome;
    logic              r_last, n_last;
    logic              mem_we;
    logic [PW-1:0]     mem_wa, mem_ra;
    t_entry            mem_wd;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_p         = r_p;
        n_new       = r_new;
        n_now       = r_now;
        n_pend_id   = r_pend_id;
        n_have_pend = r_have_pend;
        n_valid     = 1'b0;
        n_id        = r_id;
        n_outcome   = r_outcome;
        n_last      = r_last;
        mem_we      = 1'b0;
        mem_wa      = r_head;
        mem_wd      = r_new;
        mem_ra      = r_head;
        o_pop       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        OP_INSERT: begin
                            n_new.due = i_cmd.tm;
                            n_new.id  = i_cmd.id;
                            n_p       = r_count;
                            n_state   = S_INS_STEP;
                        end
                        OP_POLL: begin
                            n_now       = i_cmd.tm;
                            n_have_pend = 1'b0;
                            n_state     = S_POLL_RD;
                        end
                        default: n_state = S_CLR_RD;
                    endcase
                end
            end
            S_INS_STEP: begin
                if (r_count == CAP_C) begin
                    n_valid   = 1'b1;
                    n_id      = r_new.id;
                    n_outcome = OUT_REJECTED;
                    n_last    = 1'b1;
                    n_state   = S_IDLE;
                end else if (r_p == '0) begin
                    mem_we  = 1'b1;
                    mem_wa  = idx(r_head, r_p);
                    mem_wd  = r_new;
                    n_count = r_count + ONE;
                    n_state = S_IDLE;
                end else begin
                    mem_ra  = idx(r_head, r_p - ONE);
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                mem_we = 1'b1;
                mem_wa = idx(r_head, r_p);
                if (r_rd.due > r_new.due) begin
                    mem_wd  = r_rd;
                    n_p     = r_p - ONE;
                    n_state = S_INS_STEP;
                end else begin
                    mem_wd  = r_new;
                    n_count = r_count + ONE;
                    n_state = S_IDLE;
                end
            end
            S_POLL_RD: begin
                if (r_count == '0) begin
                    if (r_have_pend) begin
                        n_valid   = 1'b1;
                        n_id      = r_pend_id;
                        n_outcome = OUT_FIRED;
                        n_last    = 1'b1;
                    end
                    n_state = S_IDLE;
                end else begin
                    mem_ra  = r_head;
                    n_state = S_POLL_CMP;
                end
            end
            S_POLL_CMP: begin
                if (r_rd.due <= r_now) begin
                    if (r_have_pend) begin
                        n_valid   = 1'b1;
                        n_id      = r_pend_id;
                        n_outcome = OUT_FIRED;
                        n_last    = 1'b0;
                    end
                    n_pend_id   = r_rd.id;
                    n_have_pend = 1'b1;
                    n_head      = idx(r_head, ONE);
                    n_count     = r_count - ONE;
                    n_state     = S_POLL_RD;
                end else begin
                    if (r_have_pend) begin
                        n_valid   = 1'b1;
                        n_id      = r_pend_id;
                        n_outcome = OUT_FIRED;
                        n_last    = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_CLR_RD: begin
                if (r_count == '0) begin
                    n_state = S_IDLE;
                end else begin
                    mem_ra  = r_head;
                    n_state = S_CLR_OUT;
                end
            end
            S_CLR_OUT: begin
                n_valid   = 1'b1;
                n_id      = r_rd.id;
                n_outcome = OUT_RELEASED;
                n_last    = (r_count == ONE);
                n_head    = idx(r_head, ONE);
                n_count   = r_count - ONE;
                n_state   = S_CLR_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        r_p       <= n_p;
        r_new     <= n_new;
        r_now     <= n_now;
        r_pend_id <= n_pend_id;
        r_id      <= n_id;
        r_outcome <= n_outcome;
        r_last    <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_have_pend <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_have_pend <= n_have_pend;
            r_valid     <= n_valid;
        end
    end

    assign o_res_valid   = r_valid;
    assign o_unit_id_res = r_id;
    assign o_outcome     = r_outcome;
    assign o_last        = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW+1)'(r_head) < CAP_S)
        else $error("head pointer out of range");

    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_outcome == OUT_REJECTED) |-> r_last)
        else $error("reject result not marked last");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_count < CAP_C))
        else $error("write into full queue");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != S_IDLE))
        else $error("command popped without starting work");

endmodule

FILE: hdl/deadline_timer_queue.sv
// Accepts a transaction when start is high and busy is low; a two-entry command queue
// lets up to two transactions wait while the engine works.
// Insert: shifts every entry due later than the new one up a place, then stores it;
// a full queue gives a rejected result. Poll: fires each due entry from the head;
// clear: releases every entry. Results cannot be stalled by the receiver.
// Synchronous active-low reset empties the queue and the command queue at once.
module deadline_timer_queue #(
    parameter int CAPACITY = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_kind,
    input  logic [dtq_pkg::TIME_W-1:0]  i_now_ms,
    input  logic [dtq_pkg::TIME_W-1:0]  i_when_ms,
    input  logic [dtq_pkg::ID_W-1:0]    i_unit_id,
    output logic                        o_res_valid,
    output logic [dtq_pkg::ID_W-1:0]    o_unit_id_res,
    output logic [1:0]                  o_outcome,
    output logic                        o_last
);
    import dtq_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic pop;

    dtq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_now_ms    (i_now_ms),
        .i_when_ms   (i_when_ms),
        .i_unit_id   (i_unit_id),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_pop       (pop)
    );

    dtq_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cmd_valid   (cmd_valid),
        .o_pop         (pop),
        .o_res_valid   (o_res_valid),
        .o_unit_id_res (o_unit_id_res),
        .o_outcome     (o_outcome),
        .o_last        (o_last)
    );

endmodule
